FILE: rtl/number_to_english_words_assert.svh
// Assertion macros shared by the speller modules; empty when SYNTH is defined.
`ifndef NUMBER_TO_ENGLISH_WORDS_ASSERT_SVH
`define NUMBER_TO_ENGLISH_WORDS_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nte: same-cycle check failed");
// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nte: next-cycle check failed");
`else
`define NTE_ASSERT_IMP(lbl, ante, cons)
`define NTE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/nte_pkg.sv
// Shared constants, types and state encodings of the number speller.
package nte_pkg;

    localparam int VALUE_W        = 40;
    localparam int DIGITS         = 12;
    localparam int CONV_STEPS     = VALUE_W / 2;
    localparam int NTE_FIFO_DEPTH = 2;

    localparam logic [VALUE_W-1:0] LIMIT_VALUE = 40'd1000000000000;

    // Word codes.
    localparam logic [4:0] W_ZERO     = 5'd0;
    localparam logic [4:0] W_TEN      = 5'd10;
    localparam logic [4:0] W_TWENTY   = 5'd20;
    localparam logic [4:0] W_HUNDRED  = 5'd28;
    localparam logic [4:0] W_THOUSAND = 5'd29;
    localparam logic [4:0] W_MILLION  = 5'd30;
    localparam logic [4:0] W_BILLION  = 5'd31;

    // Three-digit group positions, most significant first.
    localparam logic [1:0] GRP_BILLION  = 2'd0;
    localparam logic [1:0] GRP_MILLION  = 2'd1;
    localparam logic [1:0] GRP_THOUSAND = 2'd2;
    localparam logic [1:0] GRP_UNITS    = 2'd3;

    typedef enum logic [1:0] {
        SEP_NONE   = 2'd0,
        SEP_SPACE  = 2'd1,
        SEP_HYPHEN = 2'd2
    } t_sep;

    typedef logic [3:0] t_digit;

    // One converted value waiting for the token sequencer.
    typedef struct packed {
        logic                     err;
        logic                     zero;
        t_digit [DIGITS-1:0]      digits;
    } t_entry;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        P_IDLE,
        P_SPECIAL,
        P_HDIG,
        P_HUND,
        P_TENS,
        P_ONES,
        P_SCALE,
        P_FLUSH
    } t_bstate;

endpackage

FILE: rtl/number_to_english_words.sv
// Top level of the English short-scale number speller.
// Input channel: i_valid, i_value (40 bits) and o_stall. A beat is taken at a
// rising edge with i_valid high and o_stall low. Values of 10^12 and above
// are rejected with one error beat (o_status high, o_last high).
// Output channel: o_valid, o_word, o_separator, o_last, o_status and i_stall.
// Each value gives a run of 1 to 19 word beats; o_last marks the final one.
// Per legal value the front end goes through accept, 20 steps of the
// two-bit-per-cycle binary-to-decimal converter and the queue write, and it
// takes no new value before that write; a rejected value skips the converter.
// The sequencer takes one step per hundreds digit, hundred, tens, ones or scale
// word, or one for a skipped group, plus an idle and a flush step, so with a
// ready receiver it keeps up with the front end. Skipped leading groups delay
// the first word beat of a value, as does a first word that is also the last.
// A short queue decouples the converter from the sequencer, so a stalled
// receiver only backs up the input once the queue is full.
// Reset (i_rst_n low at a clock edge) empties the queue and drops any run in
// flight; no beats are shown until new values arrive.
// While i_stall is high the presented output beat holds steady.
module number_to_english_words import nte_pkg::*; #(
    parameter int FIFO_DEPTH = NTE_FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_word,
    output logic [1:0]         o_separator,
    output logic               o_last,
    output logic               o_status
);

    logic   push;
    logic   full;
    t_entry entry;
    logic   pop;
    logic   empty;
    t_entry head;

    // Range check and binary-to-decimal conversion.
    nte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (push),
        .i_full  (full),
        .o_entry (entry)
    );

    // Converted values wait here until the sequencer has finished the
    // previous run.
    nte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // Token sequencer: walks billion, million, thousand and unit groups and
    // drives the registered output beat.
    nte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .o_separator (o_separator),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule

FILE: rtl/nte_front.sv
// Front end: accepts a value, range-checks it and converts it to decimal digits.
module nte_front import nte_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_push,
    input  logic               i_full,
    output t_entry             o_entry
);

    localparam int CNT_W = $clog2(CONV_STEPS);

    t_fstate                 r_state, n_state;
    logic [DIGITS*4-1:0]     r_bcd, n_bcd;
    logic [VALUE_W-1:0]      r_sh, n_sh;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_err, n_err;
    logic                    r_zero, n_zero;
    logic                    accept;

    // One shift-and-add-three step over all digits.
    function automatic logic [DIGITS*4-1:0] dd_step(input logic [DIGITS*4-1:0] bcd,
                                                    input logic b);
        logic [DIGITS*4-1:0] adj;
        for (int k = 0; k < DIGITS; k++) begin
            adj[k*4 +: 4] = (bcd[k*4 +: 4] >= 4'd5) ? bcd[k*4 +: 4] + 4'd3
                                                     : bcd[k*4 +: 4];
        end
        return {adj[DIGITS*4-2:0], b};
    endfunction

    assign accept = (r_state == F_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = (i_value >= LIMIT_VALUE) ? F_PUSH : F_CONV;
                end
            end
            F_CONV: begin
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_full;
    end

    always_comb begin
        n_bcd  = r_bcd;
        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_err  = r_err;
        n_zero = r_zero;
        if (accept) begin
            n_bcd  = '0;
            n_sh   = i_value;
            n_cnt  = '0;
            n_err  = (i_value >= LIMIT_VALUE);
            n_zero = (i_value == '0);
        end else if (r_state == F_CONV) begin
            n_bcd = dd_step(dd_step(r_bcd, r_sh[VALUE_W-1]), r_sh[VALUE_W-2]);
            n_sh  = {r_sh[VALUE_W-3:0], 2'b00};
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_sh   <= n_sh;
        r_cnt  <= n_cnt;
        r_err  <= n_err;
        r_zero <= n_zero;
    end

    always_comb begin
        o_entry.err    = r_err;
        o_entry.zero   = r_zero;
        o_entry.digits = r_bcd;
    end

endmodule

FILE: rtl/nte_fifo.sv
// Short queue of converted values between the front end and the sequencer.
`include "number_to_english_words_assert.svh"
module nte_fifo import nte_pkg::*; #(
    parameter int DEPTH = NTE_FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    // DEPTH must be at least two.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    `NTE_ASSERT_IMP(a_no_overflow, i_push, !o_full)
    `NTE_ASSERT_IMP(a_no_underflow, i_pop, !o_empty)
    `NTE_ASSERT_NXT(a_push_fills, i_push && !i_pop, !o_empty)

endmodule

FILE: rtl/nte_back.sv
// Back end: walks the digit groups of the queue head and emits word tokens.
`include "number_to_english_words_assert.svh"
module nte_back import nte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_word,
    output logic [1:0] o_separator,
    output logic       o_last,
    output logic       o_status
);

    t_bstate     r_state, n_state;
    logic [1:0]  r_grp, n_grp;
    logic        r_first;

    // Token held back until the next one is taken, so that the final one can be marked.
    logic        r_pend_valid;
    logic [4:0]  r_pend_word;
    t_sep        r_pend_sep;
    logic        r_pend_status;

    logic        r_out_valid;
    logic [4:0]  r_out_word;
    t_sep        r_out_sep;
    logic        r_out_last;
    logic        r_out_status;

    t_digit      dg_h, dg_t, dg_o;
    logic        gnz;
    logic        cand_valid;
    logic [4:0]  cand_word;
    logic        cand_hyph;
    logic        cand_status;
    t_sep        cand_sep;
    logic        out_free, can_take, take, flush;

    assign out_free = !r_out_valid || !i_stall;
    assign can_take = !r_pend_valid || out_free;
    assign take     = cand_valid && can_take;
    assign flush    = (r_state == P_FLUSH) && out_free;

    always_comb begin
        case (r_grp)
            GRP_BILLION: begin
                dg_h = i_head.digits[11];
                dg_t = i_head.digits[10];
                dg_o = i_head.digits[9];
            end
            GRP_MILLION: begin
                dg_h = i_head.digits[8];
                dg_t = i_head.digits[7];
                dg_o = i_head.digits[6];
            end
            GRP_THOUSAND: begin
                dg_h = i_head.digits[5];
                dg_t = i_head.digits[4];
                dg_o = i_head.digits[3];
            end
            default: begin
                dg_h = i_head.digits[2];
                dg_t = i_head.digits[1];
                dg_o = i_head.digits[0];
            end
        endcase
        gnz = (dg_h != 4'd0) || (dg_t != 4'd0) || (dg_o != 4'd0);
    end

    // Outputs of the sequencer: the candidate token of this step and the pop.
    always_comb begin
        cand_valid  = 1'b0;
        cand_word   = W_ZERO;
        cand_hyph   = 1'b0;
        cand_status = 1'b0;
        case (r_state)
            P_SPECIAL: begin
                cand_valid  = 1'b1;
                cand_status = i_head.err;
            end
            P_HDIG: begin
                cand_valid = gnz && (dg_h != 4'd0);
                cand_word  = {1'b0, dg_h};
            end
            P_HUND: begin
                cand_valid = 1'b1;
                cand_word  = W_HUNDRED;
            end
            P_TENS: begin
                cand_valid = (dg_t != 4'd0) || (dg_o != 4'd0);
                if (dg_t == 4'd1) begin
                    cand_word = W_TEN + {1'b0, dg_o};
                end else if (dg_t >= 4'd2) begin
                    cand_word = W_TWENTY + {1'b0, dg_t} - 5'd2;
                end else begin
                    cand_word = {1'b0, dg_o};
                end
            end
            P_ONES: begin
                cand_valid = 1'b1;
                cand_word  = {1'b0, dg_o};
                cand_hyph  = 1'b1;
            end
            P_SCALE: begin
                case (r_grp)
                    GRP_BILLION: begin
                        cand_valid = 1'b1;
                        cand_word  = W_BILLION;
                    end
                    GRP_MILLION: begin
                        cand_valid = 1'b1;
                        cand_word  = W_MILLION;
                    end
                    GRP_THOUSAND: begin
                        cand_valid = 1'b1;
                        cand_word  = W_THOUSAND;
                    end
                    default: cand_valid = 1'b0;
                endcase
            end
            default: cand_valid = 1'b0;
        endcase
        cand_sep = r_first ? SEP_NONE : (cand_hyph ? SEP_HYPHEN : SEP_SPACE);
        o_pop    = flush;
    end

    always_comb begin
        n_state = r_state;
        n_grp   = r_grp;
        case (r_state)
            P_IDLE: begin
                if (!i_empty) begin
                    n_grp   = GRP_BILLION;
                    n_state = (i_head.err || i_head.zero) ? P_SPECIAL : P_HDIG;
                end
            end
            P_SPECIAL: begin
                if (take) begin
                    n_state = P_FLUSH;
                end
            end
            P_HDIG: begin
                if (!gnz) begin
                    if (r_grp == GRP_UNITS) begin
                        n_state = P_FLUSH;
                    end else begin
                        n_grp = r_grp + 1'b1;
                    end
                end else if (dg_h == 4'd0) begin
                    n_state = P_TENS;
                end else if (take) begin
                    n_state = P_HUND;
                end
            end
            P_HUND: begin
                if (take) begin
                    n_state = P_TENS;
                end
            end
            P_TENS: begin
                if (!cand_valid) begin
                    n_state = P_SCALE;
                end else if (take) begin
                    n_state = ((dg_t >= 4'd2) && (dg_o != 4'd0)) ? P_ONES : P_SCALE;
                end
            end
            P_ONES: begin
                if (take) begin
                    n_state = P_SCALE;
                end
            end
            P_SCALE: begin
                if (r_grp == GRP_UNITS) begin
                    n_state = P_FLUSH;
                end else if (take) begin
                    n_state = P_HDIG;
                    n_grp   = r_grp + 1'b1;
                end
            end
            P_FLUSH: begin
                if (out_free) begin
                    n_state = P_IDLE;
                end
            end
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= P_IDLE;
            r_grp        <= GRP_BILLION;
            r_first      <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
            if (r_state == P_IDLE) begin
                r_first <= 1'b1;
            end else if (take) begin
                r_first <= 1'b0;
            end
            if (take) begin
                r_pend_valid <= 1'b1;
            end else if (flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((take && r_pend_valid) || flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((take && r_pend_valid) || flush) begin
            r_out_word   <= r_pend_word;
            r_out_sep    <= r_pend_sep;
            r_out_status <= r_pend_status;
            r_out_last   <= flush;
        end
        if (take) begin
            r_pend_word   <= cand_word;
            r_pend_sep    <= cand_sep;
            r_pend_status <= cand_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_word      = r_out_word;
    assign o_separator = r_out_sep;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

    `NTE_ASSERT_IMP(a_flush_has_token, r_state == P_FLUSH, r_pend_valid)
    `NTE_ASSERT_IMP(a_error_is_last, r_out_valid && r_out_status, r_out_last)
    `NTE_ASSERT_NXT(a_pop_ends_run, o_pop, r_state == P_IDLE && !r_pend_valid)

endmodule
